// ----- rtl/disc_pkg.sv -----
// Package for the display idle and sleep controller.
// Field widths, mode, kind and register codes, command bytes and shared types.
// No dependencies.
package disc_pkg;

  localparam int MODE_W   = 2;
  localparam int BTN_W    = 4;
  localparam int IDLE_W   = 32;
  localparam int CMD_W    = 8;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // A new change counts only once more ticks than this have passed since the last accepted change
  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS = CNT_W'(50);

  localparam logic [IDLE_W-1:0] TIMEOUT_RST    = IDLE_W'(30000);
  localparam logic [BTN_W-1:0]  ACT_LOW_RST    = '1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAKE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

  // Display kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OLED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TFT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BTN_AL  = 2'd3;

  // Command bytes
  localparam logic [CMD_W-1:0] CMD_OLED_OFF  = 8'hAE;
  localparam logic [CMD_W-1:0] CMD_OLED_ON   = 8'hAF;
  localparam logic [CMD_W-1:0] CMD_TFT_SLPIN = 8'h10;
  localparam logic [CMD_W-1:0] CMD_TFT_SLPOUT = 8'h11;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] code;
  } cmd_t;

  // Control from the top level to the debounce bank
  typedef struct packed {
    logic             tick;
    logic             poll;
    logic [BTN_W-1:0] enable;
    logic [BTN_W-1:0] active_low;
    logic [BTN_W-1:0] levels;
  } deb_ctl_t;

  // Command for a kind; wake selects the on code
  function automatic cmd_t cmd_for(input logic [KIND_W-1:0] kind, input logic wake);
    cmd_t c;
    c = '0;
    unique case (kind)
      KIND_OLED: begin
        c.valid = 1'b1;
        c.code  = wake ? CMD_OLED_ON : CMD_OLED_OFF;
      end
      KIND_TFT: begin
        c.valid = 1'b1;
        c.code  = wake ? CMD_TFT_SLPOUT : CMD_TFT_SLPIN;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/disc_ifs.sv -----
// Channel interfaces of the display idle and sleep controller.
// Depends on disc_pkg for field widths.
interface disc_in_if;
  logic                         valid;
  logic                         ready;
  logic [disc_pkg::MODE_W-1:0]  mode;
  logic [disc_pkg::BTN_W-1:0]   button_levels;
  modport source (output valid, mode, button_levels, input ready);
  modport sink   (input valid, mode, button_levels, output ready);
endinterface

interface disc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         asleep;
  logic [disc_pkg::IDLE_W-1:0]  idle_ms;
  logic                         cmd_valid;
  logic [disc_pkg::CMD_W-1:0]   cmd_byte;
  logic                         slept_event;
  logic                         woke_event;
  modport source (output valid, asleep, idle_ms, cmd_valid, cmd_byte, slept_event,
                  woke_event, input ready);
  modport sink   (input valid, asleep, idle_ms, cmd_valid, cmd_byte, slept_event,
                  woke_event, output ready);
endinterface

interface disc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [disc_pkg::CFG_IDX_W-1:0]  index;
  logic [disc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/disc_debounce.sv -----
// Debounce bank: accepted level and saturating change counter per button.
// Depends on disc_pkg.
module disc_debounce #(
  parameter int BUTTONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  disc_pkg::deb_ctl_t ctl,
  output logic               pressed
);

  logic [BUTTONS-1:0] press_vec;

  genvar i;
  generate
    for (i = 0; i < BUTTONS; i++) begin : g_btn
      logic                          acc_r;
      logic [disc_pkg::CNT_W-1:0]    cnt_r;
      logic [disc_pkg::CNT_W-1:0]    cnt_inc;
      logic                          en;
      logic                          lvl;
      logic                          al;
      logic                          take;

      if (i < disc_pkg::BTN_W) begin : g_pin
        assign en  = ctl.enable[i];
        assign lvl = ctl.levels[i];
        assign al  = ctl.active_low[i];
      end else begin : g_nopin
        // no field bit: reads as disabled
        assign en  = 1'b0;
        assign lvl = 1'b1;
        assign al  = 1'b0;
      end

      assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
      assign take    = ctl.poll && en && (lvl != acc_r) &&
                       (cnt_inc > disc_pkg::DEBOUNCE_TICKS);
      assign press_vec[i] = take && (al ? !lvl : lvl);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          acc_r <= 1'b1;
          cnt_r <= '0;
        end else if (ctl.tick) begin
          cnt_r <= take ? '0 : cnt_inc;
          if (take) begin
            acc_r <= lvl;
          end
        end
      end
    end
  endgenerate

  assign pressed = |press_vec;

endmodule

// ----- rtl/display_idle_sleep_controller.sv -----
// Display idle and sleep controller, top level.
// Depends on disc_pkg, disc_ifs (channel interfaces) and disc_debounce.
//
// Takes one transaction per clock while not stalled: a millisecond tick carrying
// the raw wake button levels, an activity/wake request or a sleep request. Each
// input transaction yields exactly one result transaction in the next cycle
// from the output register; a new input is taken whenever that register is
// empty or being drained in the same cycle, so throughput is one item per cycle
// with the output ready held high. All state (sleep flag, saturating idle count,
// per-button accepted level and change counter) is updated at the accepting
// edge by one short pass of logic, whose longest path is the 32-bit idle
// increment and compare against the timeout. Configuration writes are always
// accepted and must only be made while the block is idle.
module display_idle_sleep_controller #(
  parameter int BUTTONS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  disc_in_if.sink           in_ch,
  disc_out_if.source        out_ch,
  disc_cfg_if.sink          cfg_ch
);

  // Configuration registers
  logic [disc_pkg::KIND_W-1:0] kind_r;
  logic [disc_pkg::IDLE_W-1:0] timeout_r;
  logic [disc_pkg::BTN_W-1:0]  btn_en_r;
  logic [disc_pkg::BTN_W-1:0]  btn_al_r;

  // Controller state
  logic                        sleeping_r, sleeping_nxt;
  logic [disc_pkg::IDLE_W-1:0] idle_r, idle_nxt;
  logic [disc_pkg::IDLE_W-1:0] idle_tick;

  // Output register
  logic                        out_valid_r;
  logic                        cmd_valid_r;
  logic [disc_pkg::CMD_W-1:0]  cmd_byte_r;
  logic                        slept_r, woke_r;

  logic               in_fire;
  logic               pressed;
  logic               wake_req, sleep_req;
  logic               slept_nxt, woke_nxt;
  disc_pkg::cmd_t     cmd_nxt;
  disc_pkg::deb_ctl_t deb_ctl;

  assign cfg_ch.ready = 1'b1;
  // single output stage: accept when empty or draining
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= disc_pkg::KIND_NONE;
      timeout_r <= disc_pkg::TIMEOUT_RST;
      btn_en_r  <= '0;
      btn_al_r  <= disc_pkg::ACT_LOW_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        disc_pkg::REG_KIND:    kind_r    <= cfg_ch.data[disc_pkg::KIND_W-1:0];
        disc_pkg::REG_TIMEOUT: timeout_r <= cfg_ch.data[disc_pkg::IDLE_W-1:0];
        disc_pkg::REG_BTN_EN:  btn_en_r  <= cfg_ch.data[disc_pkg::BTN_W-1:0];
        disc_pkg::REG_BTN_AL:  btn_al_r  <= cfg_ch.data[disc_pkg::BTN_W-1:0];
        default: ;
      endcase
    end
  end

  // Button debounce; polled only on ticks with a display kind set
  assign deb_ctl.tick       = in_fire && (in_ch.mode == disc_pkg::MODE_TICK);
  assign deb_ctl.poll       = (kind_r != disc_pkg::KIND_NONE);
  assign deb_ctl.enable     = btn_en_r;
  assign deb_ctl.active_low = btn_al_r;
  assign deb_ctl.levels     = in_ch.button_levels;

  disc_debounce #(
    .BUTTONS (BUTTONS)
  ) u_deb (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (deb_ctl),
    .pressed (pressed)
  );

  assign idle_tick = (idle_r == '1) ? idle_r : idle_r + 1'b1;

  always_comb begin
    idle_nxt     = idle_r;
    wake_req     = 1'b0;
    sleep_req    = 1'b0;
    case (in_ch.mode)
      disc_pkg::MODE_TICK: begin
        // a press clears the count, so it can never also trip the timeout
        idle_nxt  = pressed ? '0 : idle_tick;
        wake_req  = pressed;
        sleep_req = (kind_r != disc_pkg::KIND_NONE) && !pressed &&
                    (timeout_r != '0) && (idle_tick > timeout_r);
      end
      disc_pkg::MODE_WAKE: begin
        idle_nxt = '0;
        wake_req = 1'b1;
      end
      disc_pkg::MODE_SLEEP: begin
        sleep_req = 1'b1;
      end
      default: ;
    endcase

    sleeping_nxt = sleeping_r;
    slept_nxt    = 1'b0;
    woke_nxt     = 1'b0;
    cmd_nxt      = '0;
    if (wake_req && sleeping_r) begin
      sleeping_nxt = 1'b0;
      woke_nxt     = 1'b1;
      cmd_nxt      = disc_pkg::cmd_for(kind_r, 1'b1);
    end else if (sleep_req && !sleeping_r) begin
      sleeping_nxt = 1'b1;
      slept_nxt    = 1'b1;
      cmd_nxt      = disc_pkg::cmd_for(kind_r, 1'b0);
    end
  end

  // State and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleeping_r  <= 1'b0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        sleeping_r  <= sleeping_nxt;
        idle_r      <= idle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_valid_r <= cmd_nxt.valid;
      cmd_byte_r  <= cmd_nxt.code;
      slept_r     <= slept_nxt;
      woke_r      <= woke_nxt;
    end
  end

  // asleep and idle_ms come straight from state: it only moves on acceptance
  assign out_ch.valid       = out_valid_r;
  assign out_ch.asleep      = sleeping_r;
  assign out_ch.idle_ms     = idle_r;
  assign out_ch.cmd_valid   = cmd_valid_r;
  assign out_ch.cmd_byte    = cmd_byte_r;
  assign out_ch.slept_event = slept_r;
  assign out_ch.woke_event  = woke_r;

endmodule

// ----- rtl/disc_checker.sv -----
// Port-level checks for the display idle and sleep controller, with bind.
// Depends on disc_pkg for field widths.
module disc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        asleep,
  input logic [disc_pkg::IDLE_W-1:0] idle_ms,
  input logic                        cmd_valid,
  input logic                        slept_event,
  input logic                        woke_event
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(slept_event && woke_event))
    else $error("sleep and wake on one transaction");

  a_slept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && slept_event |-> asleep)
    else $error("sleep event without sleep state");

  a_woke: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && woke_event |-> !asleep && (idle_ms == '0))
    else $error("wake event with stale state");

  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cmd_valid |-> slept_event || woke_event)
    else $error("command without state change");

endmodule

bind display_idle_sleep_controller disc_checker u_disc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .asleep      (out_ch.asleep),
  .idle_ms     (out_ch.idle_ms),
  .cmd_valid   (out_ch.cmd_valid),
  .slept_event (out_ch.slept_event),
  .woke_event  (out_ch.woke_event)
);
